FILE: src/dctd_pkg.sv
package dctd_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    FMT_DASH    = 2'd0,
    FMT_COMPACT = 2'd1,
    FMT_DMY     = 2'd2,
    FMT_SLASH   = 2'd3
  } fmt_t;

  localparam logic OP_DAYS  = 1'b0;
  localparam logic OP_PARTS = 1'b1;

  typedef struct packed {
    logic        missing;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [3:0]  y3;
    logic [3:0]  y2;
    logic [3:0]  y1;
    logic [3:0]  y0;
    logic [3:0]  m1;
    logic [3:0]  m0;
    logic [3:0]  d1;
    logic [3:0]  d0;
  } date_t;

endpackage

FILE: src/day_count_to_date_text.sv
// Day count or date parts to ASCII date text.
// Input channel (in_valid / in_stall): one request per date. in_op 0 converts
// in_day_count (days since 1970-01-01), in_op 1 formats in_year_in, in_month_in
// and in_day_in as given. A missing or out-of-range request yields one result
// with out_is_missing set.
// Output channel (out_valid / out_stall): one character per result, 10 per
// date (8 in the compact layout), out_last_char on the final one; year, month
// and day ride along on every character.
// cfg_wr_en / cfg_wr_data select the layout; write only while idle.
// Throughput: one character per cycle from the text stage while out_stall is
// low; the conversion pipeline takes a request every cycle while the queue has
// room. A slot is held from acceptance until the text stage picks the date up,
// so missing requests (one character each) are bounded by QUEUE_DEPTH slots.
// Up to QUEUE_DEPTH requests may be in flight; in_stall rises when all
// slots are taken. A stalled output holds its character and the queue fills.
// Reset clears the pipeline, queue and layout (dash layout), with no wait.
module day_count_to_date_text
  import dctd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [22:0] in_day_count,
  input  logic signed [15:0] in_year_in,
  input  logic signed [7:0]  in_month_in,
  input  logic signed [7:0]  in_day_in,
  input  logic               in_missing_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_text_char,
  output logic               out_last_char,
  output logic               out_is_missing,
  output logic [13:0]        out_year_out,
  output logic [6:0]         out_month_out,
  output logic [6:0]         out_day_out
);

  logic  take, room;
  logic  res_valid;
  date_t res;
  logic  q_pop, q_not_empty;
  date_t q_head;

  assign in_stall = !room;
  assign take     = in_valid && room;

  dctd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .op         (in_op),
    .day_count  (in_day_count),
    .year_in    (in_year_in),
    .month_in   (in_month_in),
    .day_in     (in_day_in),
    .missing_in (in_missing_in),
    .res_valid  (res_valid),
    .res        (res)
  );

  dctd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsv       (take),
    .room      (room),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  dctd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_text_char  (out_text_char),
    .out_last_char  (out_last_char),
    .out_is_missing (out_is_missing),
    .out_year_out   (out_year_out),
    .out_month_out  (out_month_out),
    .out_day_out    (out_day_out)
  );

endmodule

FILE: src/dctd_front.sv
module dctd_front
  import dctd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic               op,
  input  logic signed [22:0] day_count,
  input  logic signed [15:0] year_in,
  input  logic signed [7:0]  month_in,
  input  logic signed [7:0]  day_in,
  input  logic               missing_in,
  output logic               res_valid,
  output date_t              res
);

  localparam int NSTG      = 15;
  localparam int DAYS_MIN  = -719528;
  localparam int DAYS_MAX  = 2932896;
  localparam int EPOCH_OFS = 2509157;
  localparam int DIV_C     = 146097;
  localparam int RCP_C     = 229;
  localparam int DIV_E     = 1461001;
  localparam int RCP_E     = 183;
  localparam int DIV_F     = 2447;
  localparam int RCP_F     = 53;

  typedef struct packed {
    logic        miss;
    logic        op;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } side_t;

  typedef struct packed {
    logic        miss;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } ymd_t;

  function automatic logic [8:0] month_ofs(logic [3:0] f);
    logic [8:0] v;
    unique case (f)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd152;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd305;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      default: v = 9'd458;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] tens7(logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones7(logic [6:0] v, logic [3:0] t);
    logic [6:0] r;
    r = v - 7'(t) * 7'd10;
    return r[3:0];
  endfunction

  logic [NSTG:1] vld_r;
  side_t         side_r [1:10];
  ymd_t          ymd_r  [11:14];

  logic [22:0] a0_1_r, a0_2_r, a0_3_r;
  logic [7:0]  q1_2_r;
  logic [7:0]  c_3_r, c_4_r, c_5_r, c_6_r, c_7_r, c_8_r, c_9_r, c_10_r;
  logic [15:0] a1_4_r, a1_5_r, a1_6_r, a1_7_r;
  logic [27:0] x2_5_r, x2_6_r;
  logic [6:0]  q2_6_r;
  logic [6:0]  e_7_r, e_8_r, e_9_r, e_10_r;
  logic [9:0]  a2_8_r, a2_9_r, a2_10_r;
  logic [16:0] x3_9_r;
  logic [5:0]  q3_9_r;
  logic [3:0]  f_10_r;
  logic [6:0]  hi_12_r, hi_13_r, hi_14_r;
  logic [6:0]  lo_13_r, lo_14_r;
  logic [3:0]  thi_14_r, tlo_14_r, tm_14_r, td_14_r;
  date_t       res_r;

  logic               bad_days, bad_parts, miss_w;
  logic signed [23:0] a0_w;
  logic [32:0]        p2;
  logic [24:0]        m3, r3;
  logic [24:0]        t4;
  logic [22:0]        a1_w;
  logic [35:0]        p6;
  logic [27:0]        r7;
  logic [17:0]        t8;
  logic [16:0]        a2_w;
  logic [16:0]        x3_w;
  logic [22:0]        p9;
  logic [16:0]        r10;
  logic [5:0]         f_w;
  logic [8:0]         ofs;
  logic               a3;
  logic [15:0]        y_w;
  logic [9:0]         d_w;
  logic [6:0]         m_w;
  ymd_t               ymd_w;
  logic [26:0]        p12;
  logic [13:0]        lo_w;

  assign bad_days  = (day_count < 23'(DAYS_MIN)) || (day_count > 23'(DAYS_MAX));
  assign bad_parts = (year_in < 16'sd0) || (year_in > 16'sd9999) ||
                     (month_in < 8'sd0) || (month_in > 8'sd99) ||
                     (day_in < 8'sd0) || (day_in > 8'sd99);
  assign miss_w    = missing_in || ((op == OP_DAYS) ? bad_days : bad_parts);
  assign a0_w      = 24'(day_count) + 24'(EPOCH_OFS);

  assign p2   = 33'({a0_1_r, 2'b00}) * 33'(RCP_C);
  assign m3   = 25'(q1_2_r) * 25'(DIV_C);
  assign r3   = {a0_2_r, 2'b00} - m3;
  assign t4   = 25'(c_3_r) * 25'(DIV_C) + 25'd3;
  assign a1_w = a0_3_r - 23'(t4 >> 2);
  assign p6   = 36'(x2_5_r) * 36'(RCP_E);
  assign r7   = x2_6_r - 28'(q2_6_r) * 28'(DIV_E);
  assign t8   = 18'(e_7_r) * 18'd1461;
  assign a2_w = {1'b0, a1_7_r} + 17'd31 - 17'(t8 >> 2);
  assign x3_w = 17'(a2_8_r) * 17'd80;
  assign p9   = 23'(x3_w) * 23'(RCP_F);
  assign r10  = x3_9_r - 17'(q3_9_r) * 17'(DIV_F);
  assign f_w  = q3_9_r + 6'(r10 >= 17'(DIV_F));

  assign ofs = month_ofs(f_10_r);
  assign a3  = (f_10_r >= 4'd11);
  assign y_w = 16'(c_10_r) * 16'd100 + 16'(e_10_r) + 16'(a3) - 16'd4900;
  assign d_w = a2_10_r - {1'b0, ofs};
  assign m_w = a3 ? (7'(f_10_r) - 7'd10) : (7'(f_10_r) + 7'd2);

  always_comb begin
    ymd_w.miss = side_r[10].miss;
    if (side_r[10].miss) begin
      ymd_w.year  = '0;
      ymd_w.month = '0;
      ymd_w.day   = '0;
    end else if (side_r[10].op == OP_PARTS) begin
      ymd_w.year  = side_r[10].year;
      ymd_w.month = side_r[10].month;
      ymd_w.day   = side_r[10].day;
    end else begin
      ymd_w.year  = y_w[13:0];
      ymd_w.month = m_w;
      ymd_w.day   = d_w[6:0];
    end
  end

  assign p12  = 27'(ymd_r[11].year) * 27'd5243;
  assign lo_w = ymd_r[12].year - 14'(hi_12_r) * 14'd100;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-1:1], take};
    end
  end

  always_ff @(posedge clk) begin
    side_r[1].miss  <= miss_w;
    side_r[1].op    <= op;
    side_r[1].year  <= year_in[13:0];
    side_r[1].month <= month_in[6:0];
    side_r[1].day   <= day_in[6:0];
    for (int i = 2; i <= 10; i++) begin
      side_r[i] <= side_r[i-1];
    end
    a0_1_r  <= a0_w[22:0];
    q1_2_r  <= p2[32:25];
    a0_2_r  <= a0_1_r;
    c_3_r   <= q1_2_r + 8'(r3 >= 25'(DIV_C));
    a0_3_r  <= a0_2_r;
    a1_4_r  <= a1_w[15:0];
    c_4_r   <= c_3_r;
    x2_5_r  <= 28'({12'b0, a1_4_r} + 28'd1) * 28'd4000;
    a1_5_r  <= a1_4_r;
    c_5_r   <= c_4_r;
    q2_6_r  <= p6[34:28];
    x2_6_r  <= x2_5_r;
    a1_6_r  <= a1_5_r;
    c_6_r   <= c_5_r;
    e_7_r   <= q2_6_r + 7'(r7 >= 28'(DIV_E));
    a1_7_r  <= a1_6_r;
    c_7_r   <= c_6_r;
    a2_8_r  <= a2_w[9:0];
    c_8_r   <= c_7_r;
    e_8_r   <= e_7_r;
    q3_9_r  <= p9[22:17];
    x3_9_r  <= x3_w;
    a2_9_r  <= a2_8_r;
    c_9_r   <= c_8_r;
    e_9_r   <= e_8_r;
    f_10_r  <= f_w[3:0];
    a2_10_r <= a2_9_r;
    c_10_r  <= c_9_r;
    e_10_r  <= e_9_r;
    ymd_r[11] <= ymd_w;
    for (int i = 12; i <= 14; i++) begin
      ymd_r[i] <= ymd_r[i-1];
    end
    hi_12_r  <= p12[25:19];
    hi_13_r  <= hi_12_r;
    lo_13_r  <= lo_w[6:0];
    hi_14_r  <= hi_13_r;
    lo_14_r  <= lo_13_r;
    thi_14_r <= tens7(hi_13_r);
    tlo_14_r <= tens7(lo_13_r);
    tm_14_r  <= tens7(ymd_r[13].month);
    td_14_r  <= tens7(ymd_r[13].day);
    res_r.missing <= ymd_r[14].miss;
    res_r.year    <= ymd_r[14].year;
    res_r.month   <= ymd_r[14].month;
    res_r.day     <= ymd_r[14].day;
    res_r.y3      <= thi_14_r;
    res_r.y2      <= ones7(hi_14_r, thi_14_r);
    res_r.y1      <= tlo_14_r;
    res_r.y0      <= ones7(lo_14_r, tlo_14_r);
    res_r.m1      <= tm_14_r;
    res_r.m0      <= ones7(ymd_r[14].month, tm_14_r);
    res_r.d1      <= td_14_r;
    res_r.d0      <= ones7(ymd_r[14].day, td_14_r);
  end

  assign res_valid = vld_r[NSTG];
  assign res       = res_r;

endmodule

FILE: src/dctd_queue.sv
module dctd_queue
  import dctd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  rsv,
  output logic  room,
  input  logic  push,
  input  date_t push_data,
  input  logic  pop,
  output date_t head,
  output logic  not_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  date_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r, cred_r;
  logic [CW-1:0] fill_nxt, cred_nxt;

  assign fill_nxt = fill_r + CW'(push) - CW'(pop);
  assign cred_nxt = cred_r + CW'(rsv) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      cred_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      fill_r <= fill_nxt;
      cred_r <= cred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (fill_r != '0);
  assign room      = (cred_r != CW'(DEPTH));

endmodule

FILE: src/dctd_back.sv
module dctd_back
  import dctd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        q_not_empty,
  input  date_t       q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_text_char,
  output logic        out_last_char,
  output logic        out_is_missing,
  output logic [13:0] out_year_out,
  output logic [6:0]  out_month_out,
  output logic [6:0]  out_day_out
);

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_DASH  = 7'h2d;
  localparam logic [6:0] CH_SLASH = 7'h2f;

  fmt_t        fmt_r;
  date_t       cur_r;
  logic        busy_r;
  logic [3:0]  idx_r;
  logic        out_valid_r;
  logic [6:0]  char_r;
  logic        last_r, miss_r;
  logic [13:0] year_r;
  logic [6:0]  month_r, day_r;

  logic       adv, last, load;
  logic [3:0] last_idx;
  logic [6:0] txt [10];
  logic [6:0] cy3, cy2, cy1, cy0, cm1, cm0, cd1, cd0, sep;
  logic [6:0] char_w;

  assign cy3 = CH_ZERO | {3'b0, cur_r.y3};
  assign cy2 = CH_ZERO | {3'b0, cur_r.y2};
  assign cy1 = CH_ZERO | {3'b0, cur_r.y1};
  assign cy0 = CH_ZERO | {3'b0, cur_r.y0};
  assign cm1 = CH_ZERO | {3'b0, cur_r.m1};
  assign cm0 = CH_ZERO | {3'b0, cur_r.m0};
  assign cd1 = CH_ZERO | {3'b0, cur_r.d1};
  assign cd0 = CH_ZERO | {3'b0, cur_r.d0};
  assign sep = (fmt_r == FMT_DASH) ? CH_DASH : CH_SLASH;

  always_comb begin
    unique case (fmt_r)
      FMT_COMPACT: begin
        txt = '{cy3, cy2, cy1, cy0, cm1, cm0, cd1, cd0, 7'h00, 7'h00};
      end
      FMT_DMY: begin
        txt = '{cd1, cd0, sep, cm1, cm0, sep, cy3, cy2, cy1, cy0};
      end
      default: begin
        txt = '{cy3, cy2, cy1, cy0, sep, cm1, cm0, sep, cd1, cd0};
      end
    endcase
  end

  assign char_w   = cur_r.missing ? 7'h00 : txt[idx_r];
  assign last_idx = (fmt_r == FMT_COMPACT) ? 4'd7 : 4'd9;
  assign adv      = busy_r && (!out_valid_r || !out_stall);
  assign last     = cur_r.missing || (idx_r == last_idx);
  assign load     = q_not_empty && (!busy_r || (adv && last));
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_DASH;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= fmt_t'(cfg_wr_data);
      end
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (adv && last) begin
        busy_r <= 1'b0;
      end else if (adv) begin
        idx_r <= idx_r + 4'd1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_head;
    end
    if (adv) begin
      char_r  <= char_w;
      last_r  <= last;
      miss_r  <= cur_r.missing;
      year_r  <= cur_r.year;
      month_r <= cur_r.month;
      day_r   <= cur_r.day;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_text_char  = char_r;
  assign out_last_char  = last_r;
  assign out_is_missing = miss_r;
  assign out_year_out   = year_r;
  assign out_month_out  = month_r;
  assign out_day_out    = day_r;

endmodule
